### design/pdoc_pkg.sv
// Package for the periodic disk overlap checker.
// Holds store sizing, command and register codes, and the payload structs.
// No dependencies.
package pdoc_pkg;

	localparam int STORE_DEPTH = 1024;
	localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);

	localparam int COORD_W = 24;
	localparam int GAP_W = COORD_W + 1;
	localparam int SQ_W = 2 * GAP_W;
	localparam int STORED_W = 11;
	localparam int SCAN_W = 11;

	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	localparam logic [1:0] REG_BOX_WIDTH = 2'd0;
	localparam logic [1:0] REG_BOX_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DIAMETER = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [SCAN_W-1:0] scan_count;
	} pdoc_in_t;

	typedef struct packed {
		logic overlap;
		logic store_full;
		logic [STORED_W-1:0] stored_count;
	} pdoc_out_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pdoc_centre_t;

endpackage

### design/periodic_disk_overlap_check_top.sv
// Top level of the periodic disk overlap checker.
// Holds the centre store, the sequencer and the output register; uses pdoc_pkg and pdoc_square.

// The block keeps up to STORE_DEPTH disk centres and takes one command per input beat:
// clear the store, append a centre, or query a candidate centre against the leading
// scan_count stored centres (clamped to the number held). Every beat yields exactly one
// output beat. Clear and append pass straight to the done state. A query first squares
// the diameter, then walks the store one entry at a time
// through a single shared squaring unit: an entry that the raw-gap filter rejects passes
// through store read and gap compute, an entry that is fully tested through read, gaps,
// minimum-image wrap, square of x gap, square of y gap and compare. The walk stops at
// the first overlap. The input is stalled from acceptance until the result has been
// placed in the output register, which holds it while the output side stalls, so a new
// command can be accepted behind a waiting result. Configuration writes are to be made
// only while the block is idle. The store needs no clearing pass after reset; entries
// beyond the fill count are never read.
module periodic_disk_overlap_check_top (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [pdoc_pkg::COORD_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  pdoc_pkg::pdoc_in_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output pdoc_pkg::pdoc_out_t out_data
);
	import pdoc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQD,
		ST_READ,
		ST_GAP,
		ST_WRAP,
		ST_SQX,
		ST_SQY,
		ST_CMP,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [COORD_W-1:0] box_w_q;
	logic [COORD_W-1:0] box_h_q;
	logic [COORD_W-1:0] diam_q;

	// Store bookkeeping and query context.
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] limit_q;
	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;
	logic [GAP_W-1:0] gx_q;
	logic [GAP_W-1:0] gy_q;
	logic [SQ_W-1:0] acc_q;
	logic [SQ_W-1:0] dd_q;
	logic hit_q;
	logic full_q;
	logic out_valid_q;
	pdoc_out_t out_data_q;

	// Centre store and its registered read port.
	pdoc_centre_t store_mem [STORE_DEPTH];
	pdoc_centre_t rd_q;

	logic in_acc;
	logic can_append;
	logic [CNT_W-1:0] limit_nxt;
	logic [CNT_W-1:0] idx_nxt;
	logic last_entry;
	logic [GAP_W-1:0] sq_op;
	logic [SQ_W-1:0] sq_res;
	logic [COORD_W-1:0] raw_gx;
	logic [COORD_W-1:0] raw_gy;
	logic near;
	logic [GAP_W-1:0] wrap_gx;
	logic [GAP_W-1:0] wrap_gy;
	logic [SQ_W:0] dist_sq;
	logic is_hit;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign can_append = (count_q != CNT_W'(STORE_DEPTH));

	// The scan count is clamped to the number of centres held.
	always_comb begin
		if (32'(in_data.scan_count) < 32'(count_q)) begin
			limit_nxt = CNT_W'(in_data.scan_count);
		end else begin
			limit_nxt = count_q;
		end
	end

	assign idx_nxt = idx_q + CNT_W'(1);
	assign last_entry = (idx_nxt == limit_q);

	// Raw axis gaps against the fetched centre, and the cheap rejection filter.
	assign raw_gx = (rd_q.x >= px_q) ? (rd_q.x - px_q) : (px_q - rd_q.x);
	assign raw_gy = (rd_q.y >= py_q) ? (rd_q.y - py_q) : (py_q - rd_q.y);
	assign near = !((raw_gx > diam_q) && (raw_gy > diam_q));

	// Minimum image: a gap above half the box becomes the magnitude of box minus gap.
	function automatic logic [GAP_W-1:0] wrap_gap(input logic [GAP_W-1:0] gap,
			input logic [COORD_W-1:0] box);
		logic [GAP_W-1:0] box_e;
		box_e = GAP_W'(box);
		if ({gap, 1'b0} > {1'b0, box_e}) begin
			wrap_gap = (box_e >= gap) ? (box_e - gap) : (gap - box_e);
		end else begin
			wrap_gap = gap;
		end
	endfunction

	assign wrap_gx = wrap_gap(gx_q, box_w_q);
	assign wrap_gy = wrap_gap(gy_q, box_h_q);

	// Operand selection for the shared squarer.
	always_comb begin
		case (state_q)
			ST_SQD: sq_op = GAP_W'(diam_q);
			ST_SQX: sq_op = gx_q;
			ST_SQY: sq_op = gy_q;
			default: sq_op = gy_q;
		endcase
	end

	pdoc_square u_square (
		.clk(clk),
		.operand(sq_op),
		.square(sq_res)
	);

	// In the compare state the squarer output holds the square of the y gap.
	assign dist_sq = (SQ_W + 1)'(acc_q) + (SQ_W + 1)'(sq_res);
	assign is_hit = (dist_sq < (SQ_W + 1)'(dd_q));

	// Store write on an accepted append, store read when the walk fetches an entry.
	always_ff @(posedge clk) begin
		if (in_acc && (in_data.command == CMD_APPEND) && can_append) begin
			store_mem[count_q[ADDR_W-1:0]] <= '{x: in_data.pos_x, y: in_data.pos_y};
		end
		if (state_q == ST_READ) begin
			rd_q <= store_mem[idx_q[ADDR_W-1:0]];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_w_q <= COORD_W'(65536);
			box_h_q <= COORD_W'(65536);
			diam_q <= COORD_W'(256);
		end else if (cfg_write) begin
			case (cfg_index)
				REG_BOX_WIDTH: box_w_q <= cfg_data;
				REG_BOX_HEIGHT: box_h_q <= cfg_data;
				REG_DIAMETER: diam_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			limit_q <= '0;
			hit_q <= 1'b0;
			full_q <= 1'b0;
			out_valid_q <= 1'b0;
			px_q <= '0;
			py_q <= '0;
			gx_q <= '0;
			gy_q <= '0;
			acc_q <= '0;
			dd_q <= '0;
			out_data_q <= '0;
		end else begin
			// In the done state the output register is handled below.
			if (out_valid_q && !out_stall && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						hit_q <= 1'b0;
						full_q <= 1'b0;
						px_q <= in_data.pos_x;
						py_q <= in_data.pos_y;
						idx_q <= '0;
						limit_q <= limit_nxt;
						state_q <= ST_DONE;
						case (in_data.command)
							CMD_CLEAR: count_q <= '0;
							CMD_APPEND: begin
								if (can_append) begin
									count_q <= count_q + CNT_W'(1);
								end else begin
									full_q <= 1'b1;
								end
							end
							CMD_QUERY: begin
								if (limit_nxt != '0) begin
									state_q <= ST_SQD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_SQD: state_q <= ST_READ;
				ST_READ: begin
					if (idx_q == '0) begin
						dd_q <= sq_res;
					end
					state_q <= ST_GAP;
				end
				ST_GAP: begin
					gx_q <= GAP_W'(raw_gx);
					gy_q <= GAP_W'(raw_gy);
					if (near) begin
						state_q <= ST_WRAP;
					end else begin
						idx_q <= idx_nxt;
						state_q <= last_entry ? ST_DONE : ST_READ;
					end
				end
				ST_WRAP: begin
					gx_q <= wrap_gx;
					gy_q <= wrap_gy;
					state_q <= ST_SQX;
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: begin
					acc_q <= sq_res;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (is_hit) begin
						hit_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_nxt;
						state_q <= last_entry ? ST_DONE : ST_READ;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_data_q.overlap <= hit_q;
						out_data_q.store_full <= full_q;
						out_data_q.stored_count <= STORED_W'(count_q);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

`ifndef SYNTH
	// The fill count never passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= STORE_DEPTH)
		else $error("fill count beyond store depth");

	// A result never reports both an overlap and a rejected append.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.overlap && out_data.store_full))
		else $error("overlap and store_full both set");

	// An accepted clear empties the store on the next edge.
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_data.command == CMD_CLEAR)) |=> (count_q == '0))
		else $error("clear did not empty the store");

	// The walk never fetches beyond the clamped limit or the fill count.
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> ((idx_q < limit_q) && (limit_q <= count_q)))
		else $error("store walk out of range");
`endif

endmodule

### design/pdoc_square.sv
// Shared squaring unit of the periodic disk overlap checker.
// One registered 25 by 25 bit square per cycle; uses pdoc_pkg.
module pdoc_square (
	input  logic clk,
	input  logic [pdoc_pkg::GAP_W-1:0] operand,
	output logic [pdoc_pkg::SQ_W-1:0] square
);
	import pdoc_pkg::*;

	logic [SQ_W-1:0] square_q;

	always_ff @(posedge clk) begin
		square_q <= SQ_W'(operand) * SQ_W'(operand);
	end

	assign square = square_q;

endmodule

### tb/pdoc_tb_pkg.sv
// Scoreboard class for the periodic disk overlap checker testbench.
// Mirrors the centre store and registers and checks each output beat; uses pdoc_pkg.
package pdoc_tb_pkg;
	import pdoc_pkg::*;

	class disk_store_mirror;
		logic [COORD_W-1:0] box_w;
		logic [COORD_W-1:0] box_h;
		logic [COORD_W-1:0] diam;
		logic [COORD_W-1:0] cx [STORE_DEPTH];
		logic [COORD_W-1:0] cy [STORE_DEPTH];
		int unsigned held;
		int unsigned results_seen;
		int unsigned mismatches;
		pdoc_out_t awaited [$];

		function new();
			box_w = 24'd65536;
			box_h = 24'd65536;
			diam = 24'd256;
			held = 0;
			results_seen = 0;
			mismatches = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [COORD_W-1:0] val);
			case (idx)
				REG_BOX_WIDTH: box_w = val;
				REG_BOX_HEIGHT: box_h = val;
				REG_DIAMETER: diam = val;
				default: ;
			endcase
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		// Raw-gap filter, then the minimum-image distance against the diameter.
		function bit hits_entry(logic [COORD_W-1:0] qx, logic [COORD_W-1:0] qy,
				int unsigned idx);
			longint gx;
			longint gy;
			longint d;
			gx = longint'(cx[idx]) - longint'(qx);
			gy = longint'(cy[idx]) - longint'(qy);
			d = longint'(diam);
			if (gx < 0) gx = -gx;
			if (gy < 0) gy = -gy;
			if (gx > d && gy > d) return 1'b0;
			// A gap wider than the box wraps to a negative value; squaring hides the sign.
			if (2 * gx > longint'(box_w)) gx = longint'(box_w) - gx;
			if (2 * gy > longint'(box_h)) gy = longint'(box_h) - gy;
			return (gx * gx + gy * gy) < d * d;
		endfunction

		function void log_command(pdoc_in_t beat);
			pdoc_out_t res;
			int unsigned limit;
			int unsigned i;
			res = '0;
			case (beat.command)
				CMD_CLEAR: held = 0;
				CMD_APPEND: begin
					if (held >= STORE_DEPTH) begin
						res.store_full = 1'b1;
					end else begin
						cx[held] = beat.pos_x;
						cy[held] = beat.pos_y;
						held++;
					end
				end
				CMD_QUERY: begin
					limit = (beat.scan_count < held) ? beat.scan_count : held;
					for (i = 0; i < limit; i++) begin
						if (hits_entry(beat.pos_x, beat.pos_y, i)) begin
							res.overlap = 1'b1;
							break;
						end
					end
				end
				default: ;
			endcase
			res.stored_count = STORED_W'(held);
			awaited.push_back(res);
		endfunction

		task report_mismatch(string msg);
			mismatches++;
			$display("output beat %0d: %s", results_seen, msg);
		endtask

		task check_result(pdoc_out_t got);
			pdoc_out_t want;
			results_seen++;
			if (awaited.size() == 0) begin
				report_mismatch($sformatf("arrived with nothing awaited (%h)", got));
				return;
			end
			want = awaited.pop_front();
			if (got.overlap !== want.overlap)
				report_mismatch($sformatf("overlap %b, expected %b", got.overlap, want.overlap));
			if (got.store_full !== want.store_full)
				report_mismatch($sformatf("store_full %b, expected %b",
					got.store_full, want.store_full));
			if (got.stored_count !== want.stored_count)
				report_mismatch($sformatf("stored_count %0d, expected %0d",
					got.stored_count, want.stored_count));
		endtask
	endclass

endpackage

### tb/tb.sv
// Top-level testbench for periodic_disk_overlap_check_top.
// Drives commands and register writes, mirrors the block in pdoc_tb_pkg and checks every beat.
// Depends on pdoc_pkg and pdoc_tb_pkg.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pdoc_pkg::*;
	import pdoc_tb_pkg::*;

	// Command code 3 is unused by the block and must act as a no-operation.
	localparam logic [1:0] CMD_NOP = 2'd3;
	// Register index 3 addresses nothing; writes to it must be ignored.
	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam logic [COORD_W-1:0] COORD_MAX = '1;
	localparam logic [SCAN_W-1:0] SCAN_MAX = '1;
	// Length of the long output hold-off used to back the block up.
	localparam int HOLD_LEN = 400;
	// A full-store query runs without any beat moving, so the watchdog limit must outlast it.
	localparam int QUIET_LIMIT = 30000;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic [1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	pdoc_in_t in_data;
	logic out_valid;
	logic out_stall;
	pdoc_out_t out_data;

	disk_store_mirror mirror;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left;
	int quiet_cycles = 0;
	int items_sent = 0;

	periodic_disk_overlap_check_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Everything is sampled at the rising edge. Inputs only change at the falling edge and
	// the block's outputs are updated by its flops, so the values seen here are settled.
	// The same process keeps the watchdog: cycles in which no beat moves on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) mirror.log_command(in_data);
			if (out_valid && !out_stall) mirror.check_result(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Output side. It stalls at random at the current rate, except when a long hold-off
	// has been requested; the hold-off is counted here, independently of the sender,
	// which keeps offering beats so that the block fills and stalls its input.
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request && hold_left == 0) begin
				hold_request = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	function automatic pdoc_in_t make_beat(input logic [1:0] cmd, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [SCAN_W-1:0] scan);
		pdoc_in_t b;
		b.command = cmd;
		b.pos_x = x;
		b.pos_y = y;
		b.scan_count = scan;
		return b;
	endfunction

	// Mostly inside the box; now and then any 24-bit value, which may lie beyond it.
	function automatic logic [COORD_W-1:0] coord_in_box(input logic [COORD_W-1:0] box);
		if ($urandom_range(19) == 0) return COORD_W'($urandom);
		return COORD_W'($urandom_range(box - 1));
	endfunction

	// A coordinate within about two diameters of a stored one. Usually folded back into
	// the box, which exercises the wrap; otherwise left to run past the 24-bit edge.
	function automatic logic [COORD_W-1:0] coord_near(input logic [COORD_W-1:0] centre,
			input logic [COORD_W-1:0] box);
		longint span;
		longint v;
		span = 2 * longint'(mirror.diam) + 2;
		if (span > longint'(COORD_MAX)) span = longint'(COORD_MAX);
		v = longint'(centre) + longint'($urandom_range(2 * span)) - span;
		if ($urandom_range(4) == 0) return COORD_W'(v);
		v = v % longint'(box);
		if (v < 0) v += longint'(box);
		return COORD_W'(v);
	endfunction

	// Scan counts: mostly the whole store, sometimes a prefix, sometimes clamped values.
	function automatic logic [SCAN_W-1:0] pick_scan();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45) return SCAN_W'(mirror.held);
		if (r < 65) return SCAN_W'($urandom_range(mirror.held));
		if (r < 85) return SCAN_W'($urandom);
		return SCAN_W'(STORE_DEPTH);
	endfunction

	// Offers one input beat, called at a falling edge. Idle cycles go in front of the beat
	// at the current rate; the task returns at the falling edge after the beat was taken.
	task automatic send_command(input pdoc_in_t beat);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= beat;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (beat.command != CMD_NOP) items_sent++;
	endtask

	// Holds the input off until every awaited result has been taken.
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (mirror.outstanding() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [COORD_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		mirror.set_register(idx, val);
		@(negedge clk);
	endtask

	// Registers are only written once the block has drained.
	task automatic apply_setting(input logic [COORD_W-1:0] bw, input logic [COORD_W-1:0] bh,
			input logic [COORD_W-1:0] dia);
		wait_for_results();
		write_register(REG_BOX_WIDTH, bw);
		write_register(REG_BOX_HEIGHT, bh);
		write_register(REG_DIAMETER, dia);
	endtask

	task automatic send_append();
		int unsigned idx;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		if (mirror.held > 0 && mirror.held < STORE_DEPTH && $urandom_range(9) < 3) begin
			idx = $urandom_range(mirror.held - 1);
			x = coord_near(mirror.cx[idx], mirror.box_w);
			y = coord_near(mirror.cy[idx], mirror.box_h);
		end else begin
			x = coord_in_box(mirror.box_w);
			y = coord_in_box(mirror.box_h);
		end
		send_command(make_beat(CMD_APPEND, x, y, SCAN_W'($urandom)));
	endtask

	// Three queries in four aim close to a stored centre so that hits are common.
	task automatic send_query(input logic [SCAN_W-1:0] scan);
		int unsigned idx;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		if (mirror.held > 0 && $urandom_range(3) != 0) begin
			idx = $urandom_range(mirror.held - 1);
			x = coord_near(mirror.cx[idx], mirror.box_w);
			y = coord_near(mirror.cy[idx], mirror.box_h);
		end else begin
			x = coord_in_box(mirror.box_w);
			y = coord_in_box(mirror.box_h);
		end
		send_command(make_beat(CMD_QUERY, x, y, scan));
	endtask

	// Mostly well-formed rounds (clear, a few appends, a few queries) with some raw noise
	// mixed in. The store is cleared before it grows large so that queries stay short.
	task automatic run_random_phase(input int beats);
		int stop_at;
		int n;
		int k;
		stop_at = items_sent + beats;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 12 && mirror.held < 150) begin
				send_command(make_beat(2'($urandom), COORD_W'($urandom), COORD_W'($urandom),
					SCAN_W'($urandom)));
			end else begin
				if ($urandom_range(3) != 0 || mirror.held > 150)
					send_command(make_beat(CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
						SCAN_W'($urandom)));
				n = $urandom_range(1, 12);
				for (k = 0; k < n; k++) send_append();
				n = $urandom_range(1, 6);
				for (k = 0; k < n; k++) send_query(pick_scan());
			end
		end
	endtask

	initial begin
		mirror = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// First stretch: sender idles a quarter of the time, receiver most of the time.
		send_idle_pct = 26;
		recv_stall_pct = 82;

		// Directed beats at the reset setting: box 256.0 square, diameter 1.0.
		send_command(make_beat(CMD_QUERY, COORD_MAX, COORD_MAX, SCAN_MAX)); // empty store
		send_command(make_beat(CMD_APPEND, '0, '0, '0));
		send_command(make_beat(CMD_APPEND, COORD_MAX, COORD_MAX, SCAN_MAX)); // far outside box
		send_command(make_beat(CMD_APPEND, 24'd65535, 24'd100, '0)); // at the right edge
		send_command(make_beat(CMD_QUERY, '0, '0, '0)); // nothing scanned
		send_command(make_beat(CMD_QUERY, '0, '0, 11'd1)); // exact coincidence
		send_command(make_beat(CMD_QUERY, 24'd255, '0, SCAN_MAX)); // just inside, clamped scan
		send_command(make_beat(CMD_QUERY, 24'd256, '0, 11'd3)); // touching is not overlap
		send_command(make_beat(CMD_QUERY, 24'd200, 24'd100, 11'd3));
		// Raw x gap is nearly the box, so only the wrapped gap makes this a hit.
		send_command(make_beat(CMD_QUERY, 24'd65400, 24'd100, 11'd3));
		// Gaps wider than the box wrap to negative values and must not overlap.
		send_command(make_beat(CMD_QUERY, COORD_MAX, '0, 11'd3));
		send_command(make_beat(CMD_NOP, COORD_MAX, COORD_MAX, SCAN_MAX));
		send_command(make_beat(CMD_NOP, '0, '0, '0));
		send_command(make_beat(CMD_CLEAR, COORD_MAX, COORD_MAX, SCAN_MAX));
		send_command(make_beat(CMD_QUERY, '0, '0, SCAN_MAX)); // old entries stay hidden
		send_command(make_beat(CMD_APPEND, 24'h800000, 24'h7FFFFF, 11'h400));
		send_command(make_beat(CMD_APPEND, 24'h7FFFFF, 24'h800000, 11'h3FF));
		send_command(make_beat(CMD_QUERY, 24'h7FFFFF, 24'h800000, SCAN_W'(STORE_DEPTH)));
		send_command(make_beat(CMD_CLEAR, '0, '0, '0));

		apply_setting(24'd4096, 24'd3072, 24'd300);
		run_random_phase(95);
		// Largest box and diameter; the spare register index is written once on the way.
		wait_for_results();
		write_register(REG_SPARE, 24'h000010);
		apply_setting(COORD_MAX, COORD_MAX, COORD_MAX);
		run_random_phase(95);

		// Second stretch: the roles swap.
		send_idle_pct = 82;
		recv_stall_pct = 26;
		// Smallest box and a zero diameter, under which nothing may overlap. The output
		// is held off for a long time here while beats keep being offered.
		apply_setting(24'd1, 24'd1, 24'd0);
		hold_request = 1'b1;
		send_idle_pct = 0;
		run_random_phase(30);
		send_idle_pct = 82;
		run_random_phase(65);
		apply_setting(24'd2000, 24'd65536, 24'd1000);
		run_random_phase(95);

		// Last stretch: no idling on either side.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		apply_setting(24'd777, 24'd12345, 24'd5000);
		run_random_phase(95);
		apply_setting(24'd300000, 24'd200, 24'd64);
		run_random_phase(95);

		wait_for_results();
		repeat (8) @(posedge clk);
		if (mirror.mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
